// File: hdl/waypoint_frame_transform_assert.svh
// Assertion macros for the waypoint frame transform.
`ifndef WAYPOINT_FRAME_TRANSFORM_ASSERT_SVH
`define WAYPOINT_FRAME_TRANSFORM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("waypoint_frame_transform: assertion failed");
`define WFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("waypoint_frame_transform: assertion failed");
`else
`define WFT_ASSERT_IMP(label, ante, cons)
`define WFT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/wft_pkg.sv
package wft_pkg;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned ATAN_ENTRIES  = 32;
  localparam int unsigned CORDIC_USED   =
      (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  localparam int unsigned PRE_STAGES  = 5;
  localparam int unsigned POST_STAGES = 3;
  localparam int unsigned PIPE_STAGES = PRE_STAGES + CORDIC_USED + POST_STAGES;

  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned PX_SHIFT   = 32 - GUARD_BITS;
  localparam int unsigned X0_W       = 64 - PX_SHIFT;
  localparam int unsigned POS_W      = 43;
  localparam int unsigned RX_W       = POS_W - GUARD_BITS;
  localparam int unsigned SUM_W      = RX_W + 1;
  localparam int unsigned SAT_IN_W   = SUM_W + 1;
  localparam int unsigned ANG_W      = 33;
  localparam int unsigned QUAT_W     = 34;
  localparam int unsigned QUAT_DROP  = 16;
  localparam int unsigned QR_W       = QUAT_W - QUAT_DROP;

  localparam logic signed [32:0] GAIN_Q32 = 33'sd2608131496;
  localparam logic signed [QUAT_W-1:0] QUAT_X0 = QUAT_W'(64'd2608131496 / 64'd4);
  localparam logic signed [QR_W-1:0] QUAT_ONE = QR_W'(16384);

  localparam logic signed [18:0] UNITS_PER_TURN      = 19'sd46080;
  localparam logic signed [18:0] HALF_UNITS_PER_TURN = 19'sd92160;
  localparam logic signed [18:0] QUARTER_TURN_UNITS  = 19'sd11520;

  // turn = q * 2^frac + lut[r] where m = 45 q + r
  localparam int unsigned TURN_DIV       = 45;
  localparam int unsigned TURN_ROUND     = 22;
  localparam int unsigned TURN_IDX_W     = $clog2(TURN_DIV);
  localparam int unsigned RECIP_SHIFT    = 23;
  localparam logic [17:0] RECIP          = 18'd186414;
  localparam int unsigned ROT_FRAC_BITS  = 22;
  localparam int unsigned HALF_FRAC_BITS = 21;
  localparam int unsigned Q_ROT_W        = 32 - ROT_FRAC_BITS;
  localparam int unsigned Q_HALF_W       = 32 - HALF_FRAC_BITS;

  typedef enum logic [1:0] {
    REG_HEADING_CORR,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_OFFSET_Z
  } cfg_reg_e;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335086,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
    32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
  };

  typedef logic [ROT_FRAC_BITS-1:0] frac_lut_t [TURN_DIV];

  function automatic frac_lut_t frac_lut(input int unsigned frac_bits);
    frac_lut_t lut;
    for (int unsigned r = 0; r < TURN_DIV; r++) begin
      lut[r] = ROT_FRAC_BITS'(((64'(r) << frac_bits) + 64'(TURN_ROUND)) / 64'(TURN_DIV));
    end
    return lut;
  endfunction

  localparam frac_lut_t FRAC_LUT_ROT  = frac_lut(ROT_FRAC_BITS);
  localparam frac_lut_t FRAC_LUT_HALF = frac_lut(HALF_FRAC_BITS);

  localparam logic signed [SAT_IN_W-1:0] SAT_MAX = SAT_IN_W'(64'sd2147483647);
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN = SAT_IN_W'(-64'sd2147483648);

  function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [31:0] res;
    if (v > SAT_MAX) begin
      res = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [QR_W-1:0] v);
    logic signed [15:0] res;
    if (v > QUAT_ONE) begin
      res = 16'(QUAT_ONE);
    end else if (v < -QUAT_ONE) begin
      res = 16'(-QUAT_ONE);
    end else begin
      res = 16'(v);
    end
    return res;
  endfunction

  typedef struct packed {
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
    logic signed [31:0] dest_z;
    logic signed [31:0] dest_y;
    logic signed [31:0] dest_x;
  } result_t;

endpackage

// File: hdl/waypoint_frame_transform.sv
// Channel   Direction  Handshake                       Payload
// cfg       in         cfg_we_i                        cfg_idx_i, cfg_wdata_i
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o target x, y, z, desired heading
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i dest x, y, z, orient w, z
//
// One transaction per cycle while the skid register is empty; the path runs through
// one pipeline stage per CORDIC micro-rotation plus reduction and rounding stages.
// Reset clears the configuration registers and all valid bits; no clearing pass.
// A skid register behind the output register takes a result while the output is
// stalled; s_axis_tready_o drops only while the skid register is full, freezing the pipe.
`include "waypoint_frame_transform_assert.svh"

module waypoint_frame_transform (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // target_x, target_y, target_z, desired_heading, zero pad
  input  logic [119:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // dest_x, dest_y, dest_z, orient_w, orient_z
  output logic [127:0] m_axis_tdata_o
);

  localparam int unsigned NSTG = wft_pkg::PIPE_STAGES;
  localparam int unsigned NCOR = wft_pkg::CORDIC_USED;
  localparam int unsigned POS_W = wft_pkg::POS_W;
  localparam int unsigned ANG_W = wft_pkg::ANG_W;
  localparam int unsigned QUAT_W = wft_pkg::QUAT_W;
  localparam int unsigned X0_W = wft_pkg::X0_W;
  localparam int unsigned RX_W = wft_pkg::RX_W;
  localparam int unsigned SUM_W = wft_pkg::SUM_W;
  localparam int unsigned SAT_IN_W = wft_pkg::SAT_IN_W;
  localparam int unsigned QR_W = wft_pkg::QR_W;
  localparam int unsigned IDX_W = wft_pkg::TURN_IDX_W;
  localparam int unsigned QRW = wft_pkg::Q_ROT_W;
  localparam int unsigned QHW = wft_pkg::Q_HALF_W;
  localparam int unsigned HFB = wft_pkg::HALF_FRAC_BITS;
  localparam logic signed [63:0] PX_ROUND = 64'sd1 <<< (wft_pkg::PX_SHIFT - 1);
  localparam logic signed [POS_W-1:0] POS_ROUND = POS_W'(1) <<< (wft_pkg::GUARD_BITS - 1);
  localparam logic signed [QUAT_W-1:0] QUAT_ROUND = QUAT_W'(1) <<< (wft_pkg::QUAT_DROP - 1);

  logic signed [16:0] hc_q;
  logic signed [31:0] ox_q, oy_q, oz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= '0;
    end else if (cfg_we_i) begin
      case (wft_pkg::cfg_reg_e'(cfg_idx_i))
        wft_pkg::REG_HEADING_CORR: hc_q <= cfg_wdata_i[16:0];
        wft_pkg::REG_OFFSET_X:     ox_q <= cfg_wdata_i;
        wft_pkg::REG_OFFSET_Y:     oy_q <= cfg_wdata_i;
        wft_pkg::REG_OFFSET_Z:     oz_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NSTG-1:0] v_q;
  logic            out_v_q, skid_v_q;
  logic            en, out_take;
  wft_pkg::result_t res_d, res_q, out_q, skid_q;

  assign en = !skid_v_q;
  assign out_take = m_axis_tready_i || !out_v_q;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = out_q;

  // stage 0: capture and reduce angles into one period
  logic signed [31:0] in_tx, in_ty, in_tz;
  logic signed [16:0] in_dh;
  logic signed [18:0] a_rot, a_half;
  logic [15:0] s0_m_rot_d, s0_m_rot_q;
  logic [16:0] s0_m_half_d, s0_m_half_q;
  logic signed [31:0] s0_tx_q, s0_ty_q, s0_tz_q;

  assign in_tx = s_axis_tdata_i[31:0];
  assign in_ty = s_axis_tdata_i[63:32];
  assign in_tz = s_axis_tdata_i[95:64];
  assign in_dh = s_axis_tdata_i[112:96];
  assign a_rot = 19'(hc_q) - wft_pkg::QUARTER_TURN_UNITS;
  assign a_half = 19'(in_dh) + 19'(hc_q);

  always_comb begin
    if (a_rot >= wft_pkg::UNITS_PER_TURN) begin
      s0_m_rot_d = 16'(a_rot - wft_pkg::UNITS_PER_TURN);
    end else if (a_rot >= 19'sd0) begin
      s0_m_rot_d = 16'(a_rot);
    end else if (a_rot >= -wft_pkg::UNITS_PER_TURN) begin
      s0_m_rot_d = 16'(a_rot + wft_pkg::UNITS_PER_TURN);
    end else begin
      s0_m_rot_d = 16'(a_rot + wft_pkg::UNITS_PER_TURN + wft_pkg::UNITS_PER_TURN);
    end
    if (a_half >= wft_pkg::HALF_UNITS_PER_TURN) begin
      s0_m_half_d = 17'(a_half - wft_pkg::HALF_UNITS_PER_TURN);
    end else if (a_half >= 19'sd0) begin
      s0_m_half_d = 17'(a_half);
    end else if (a_half >= -wft_pkg::HALF_UNITS_PER_TURN) begin
      s0_m_half_d = 17'(a_half + wft_pkg::HALF_UNITS_PER_TURN);
    end else begin
      s0_m_half_d = 17'(a_half + wft_pkg::HALF_UNITS_PER_TURN + wft_pkg::HALF_UNITS_PER_TURN);
    end
  end

  // stage 1: gain multiply, quotient by reciprocal, z sum
  logic signed [63:0] s1_px_d, s1_py_d, s1_px_q, s1_py_q;
  logic [33:0] prod_rot;
  logic [34:0] prod_half;
  logic [QRW-1:0] s1_q_rot_q, s2_q_rot_q;
  logic [QHW-1:0] s1_q_half_q, s2_q_half_q;
  logic [15:0] s1_m_rot_q;
  logic [16:0] s1_m_half_q;
  logic signed [31:0] s1_dz_d, s1_dz_q, s2_dz_q, s3_dz_q;

  assign s1_px_d = 64'(s0_tx_q) * 64'(wft_pkg::GAIN_Q32);
  assign s1_py_d = 64'(s0_ty_q) * 64'(wft_pkg::GAIN_Q32);
  assign prod_rot = 34'(s0_m_rot_q) * 34'(wft_pkg::RECIP);
  assign prod_half = 35'(s0_m_half_q) * 35'(wft_pkg::RECIP);
  assign s1_dz_d = wft_pkg::sat32(SAT_IN_W'(s0_tz_q) + SAT_IN_W'(oz_q));

  // stage 2: round positions to guard bits, remainders
  logic signed [X0_W-1:0] s2_x0_d, s2_y0_d, s2_x0_q, s2_y0_q, s3_x0_q, s3_y0_q;
  logic [IDX_W-1:0] s2_r_rot_d, s2_r_half_d, s2_r_rot_q, s2_r_half_q;

  assign s2_x0_d = X0_W'((s1_px_q + PX_ROUND) >>> wft_pkg::PX_SHIFT);
  assign s2_y0_d = X0_W'((s1_py_q + PX_ROUND) >>> wft_pkg::PX_SHIFT);
  assign s2_r_rot_d = IDX_W'(s1_m_rot_q - 16'(s1_q_rot_q) * 16'(wft_pkg::TURN_DIV));
  assign s2_r_half_d = IDX_W'(s1_m_half_q - 17'(s1_q_half_q) * 17'(wft_pkg::TURN_DIV));

  // stage 3: binary turns
  logic [31:0] s3_turn_rot_d, s3_turn_half_d, s3_turn_rot_q, s3_turn_half_q;
  logic [wft_pkg::ROT_FRAC_BITS-1:0] frac_half;

  assign frac_half = wft_pkg::FRAC_LUT_HALF[s2_r_half_q];
  assign s3_turn_rot_d = {s2_q_rot_q, wft_pkg::FRAC_LUT_ROT[s2_r_rot_q]};
  assign s3_turn_half_d = {s2_q_half_q, frac_half[HFB-1:0]};

  // stage 4: fold into half turn, then micro-rotations
  logic signed [POS_W-1:0] cx_q [NCOR+1];
  logic signed [POS_W-1:0] cy_q [NCOR+1];
  logic signed [ANG_W-1:0] cz_q [NCOR+1];
  logic signed [QUAT_W-1:0] qx_q [NCOR+1];
  logic signed [QUAT_W-1:0] qy_q [NCOR+1];
  logic signed [ANG_W-1:0] qa_q [NCOR+1];
  logic signed [31:0] cdz_q [NCOR+1];
  logic flip_rot, flip_half;
  logic signed [POS_W-1:0] s4_x_d, s4_y_d;
  logic signed [ANG_W-1:0] s4_z_d, s4_qa_d;
  logic signed [QUAT_W-1:0] s4_qx_d;

  assign flip_rot = s3_turn_rot_q[31] ^ s3_turn_rot_q[30];
  assign flip_half = s3_turn_half_q[31] ^ s3_turn_half_q[30];
  assign s4_x_d = flip_rot ? -POS_W'(s3_x0_q) : POS_W'(s3_x0_q);
  assign s4_y_d = flip_rot ? -POS_W'(s3_y0_q) : POS_W'(s3_y0_q);
  assign s4_z_d = ANG_W'($signed({s3_turn_rot_q[31] ^ flip_rot, s3_turn_rot_q[30:0]}));
  assign s4_qx_d = flip_half ? -wft_pkg::QUAT_X0 : wft_pkg::QUAT_X0;
  assign s4_qa_d = ANG_W'($signed({s3_turn_half_q[31] ^ flip_half, s3_turn_half_q[30:0]}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_tx_q <= in_tx;
      s0_ty_q <= in_ty;
      s0_tz_q <= in_tz;
      s0_m_rot_q <= s0_m_rot_d;
      s0_m_half_q <= s0_m_half_d;
      s1_px_q <= s1_px_d;
      s1_py_q <= s1_py_d;
      s1_q_rot_q <= prod_rot[wft_pkg::RECIP_SHIFT +: QRW];
      s1_q_half_q <= prod_half[wft_pkg::RECIP_SHIFT +: QHW];
      s1_m_rot_q <= s0_m_rot_q;
      s1_m_half_q <= s0_m_half_q;
      s1_dz_q <= s1_dz_d;
      s2_x0_q <= s2_x0_d;
      s2_y0_q <= s2_y0_d;
      s2_r_rot_q <= s2_r_rot_d;
      s2_r_half_q <= s2_r_half_d;
      s2_q_rot_q <= s1_q_rot_q;
      s2_q_half_q <= s1_q_half_q;
      s2_dz_q <= s1_dz_q;
      s3_turn_rot_q <= s3_turn_rot_d;
      s3_turn_half_q <= s3_turn_half_d;
      s3_x0_q <= s2_x0_q;
      s3_y0_q <= s2_y0_q;
      s3_dz_q <= s2_dz_q;
      cx_q[0] <= s4_x_d;
      cy_q[0] <= s4_y_d;
      cz_q[0] <= s4_z_d;
      qx_q[0] <= s4_qx_d;
      qy_q[0] <= '0;
      qa_q[0] <= s4_qa_d;
      cdz_q[0] <= s3_dz_q;
    end
  end

  for (genvar i = 0; i < NCOR; i++) begin : g_cordic
    logic signed [POS_W-1:0] cx_d, cy_d;
    logic signed [ANG_W-1:0] cz_d, qa_d;
    logic signed [QUAT_W-1:0] qx_d, qy_d;
    logic signed [ANG_W-1:0] atan_i;

    assign atan_i = $signed(ANG_W'(wft_pkg::ATAN_TURNS[i]));

    always_comb begin
      if (!cz_q[i][ANG_W-1]) begin
        cx_d = cx_q[i] - (cy_q[i] >>> i);
        cy_d = cy_q[i] + (cx_q[i] >>> i);
        cz_d = cz_q[i] - atan_i;
      end else begin
        cx_d = cx_q[i] + (cy_q[i] >>> i);
        cy_d = cy_q[i] - (cx_q[i] >>> i);
        cz_d = cz_q[i] + atan_i;
      end
      if (!qa_q[i][ANG_W-1]) begin
        qx_d = qx_q[i] - (qy_q[i] >>> i);
        qy_d = qy_q[i] + (qx_q[i] >>> i);
        qa_d = qa_q[i] - atan_i;
      end else begin
        qx_d = qx_q[i] + (qy_q[i] >>> i);
        qy_d = qy_q[i] - (qx_q[i] >>> i);
        qa_d = qa_q[i] + atan_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[i+1] <= cx_d;
        cy_q[i+1] <= cy_d;
        cz_q[i+1] <= cz_d;
        qx_q[i+1] <= qx_d;
        qy_q[i+1] <= qy_d;
        qa_q[i+1] <= qa_d;
        cdz_q[i+1] <= cdz_q[i];
      end
    end
  end

  // post stages: drop guard bits, add offsets, negate and saturate
  logic signed [RX_W-1:0] f1_rx_d, f1_ry_d, f1_rx_q, f1_ry_q;
  logic signed [QR_W-1:0] f1_qw_d, f1_qz_d, f1_qw_q, f1_qz_q;
  logic signed [31:0] f1_dz_q, f2_dz_q;
  logic signed [SUM_W-1:0] f2_sx_d, f2_sy_d, f2_sx_q, f2_sy_q;
  logic signed [15:0] f2_qw_q, f2_qz_q;

  assign f1_rx_d = RX_W'((cx_q[NCOR] + POS_ROUND) >>> wft_pkg::GUARD_BITS);
  assign f1_ry_d = RX_W'((cy_q[NCOR] + POS_ROUND) >>> wft_pkg::GUARD_BITS);
  assign f1_qw_d = QR_W'((qx_q[NCOR] + QUAT_ROUND) >>> wft_pkg::QUAT_DROP);
  assign f1_qz_d = QR_W'((qy_q[NCOR] + QUAT_ROUND) >>> wft_pkg::QUAT_DROP);
  assign f2_sx_d = SUM_W'(f1_rx_q) + SUM_W'(ox_q);
  assign f2_sy_d = SUM_W'(f1_ry_q) + SUM_W'(oy_q);

  always_comb begin
    res_d.dest_x = wft_pkg::sat32(-SAT_IN_W'(f2_sx_q));
    res_d.dest_y = wft_pkg::sat32(-SAT_IN_W'(f2_sy_q));
    res_d.dest_z = f2_dz_q;
    res_d.orient_w = f2_qw_q;
    res_d.orient_z = f2_qz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_rx_q <= f1_rx_d;
      f1_ry_q <= f1_ry_d;
      f1_qw_q <= f1_qw_d;
      f1_qz_q <= f1_qz_d;
      f1_dz_q <= cdz_q[NCOR];
      f2_sx_q <= f2_sx_d;
      f2_sy_q <= f2_sy_d;
      f2_qw_q <= wft_pkg::clamp_unit(f1_qw_q);
      f2_qz_q <= wft_pkg::clamp_unit(f1_qz_q);
      f2_dz_q <= f1_dz_q;
      res_q <= res_d;
    end
  end

  // valid bits, output register and skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        v_q <= {v_q[NSTG-2:0], s_axis_tvalid_i};
      end
      if (skid_v_q) begin
        if (out_take) begin
          out_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end
      end else if (out_take) begin
        out_v_q <= v_q[NSTG-1];
      end else begin
        skid_v_q <= v_q[NSTG-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (out_take) begin
      out_q <= res_q;
    end else begin
      skid_q <= res_q;
    end
  end

  `WFT_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
  `WFT_ASSERT_NEXT(a_skid_catches, out_v_q && !m_axis_tready_i && !skid_v_q && v_q[NSTG-1], skid_v_q)
  `WFT_ASSERT_NEXT(a_skid_drains, skid_v_q && m_axis_tready_i, out_v_q && !skid_v_q)

endmodule
